// ----- src/cte_pkg.sv -----
// Shared types and constants for the calendar-to-epoch-seconds unit.
// Holds the payload structs and the cumulative month table.
// Depends on nothing; imported by every module of the unit.
`default_nettype none

package cte_pkg;

    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    localparam int DAYS_W   = 16;
    localparam int MOD_W    = 11;
    localparam int TICK_W   = 12;
    localparam int TOTAL_W  = 32;
    localparam int MOFF_W   = 9;

    // Days from 1978-01-01 to 2000-01-01: 22 years with five leap days.
    localparam logic [DAYS_W-1:0]  DAYS_TO_2000   = 16'd8035;
    localparam logic [DAYS_W-1:0]  DAYS_PER_YEAR  = 16'd365;
    localparam logic [YEAR_W-1:0]  YEAR_2100      = 7'd100;
    localparam logic [MONTH_W-1:0] MONTH_MARCH    = 4'd3;
    localparam logic [TOTAL_W-1:0] SECS_PER_DAY   = 32'd86400;
    localparam logic [TOTAL_W-1:0] SECS_PER_MIN   = 32'd60;
    localparam logic [MOD_W-1:0]   MINS_PER_HOUR  = 11'd60;

    typedef struct packed {
        logic [YEAR_W-1:0]   year_in_century;
        logic [MONTH_W-1:0]  month_number;
        logic [DAY_W-1:0]    day_of_month;
        logic [HOUR_W-1:0]   hour_of_day;
        logic [MINUTE_W-1:0] minute_of_hour;
        logic [SECOND_W-1:0] second_of_minute;
    } t_in_data;

    // Partial result handed from the date stage to the seconds stage.
    typedef struct packed {
        logic [DAYS_W-1:0]   day_count;
        logic [MOD_W-1:0]    minute_of_day;
        logic [TICK_W-1:0]   tick_count;
        logic [SECOND_W-1:0] second_of_minute;
    } t_mid_data;

    typedef struct packed {
        logic [DAYS_W-1:0]  day_count;
        logic [MOD_W-1:0]   minute_of_day;
        logic [TICK_W-1:0]  tick_count;
        logic [TOTAL_W-1:0] total_seconds;
    } t_out_data;

    // Days in a common year before the first of the given month. Month zero
    // acts as January and months above twelve act as December.
    function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [MOFF_W-1:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            default: r = 9'd334;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/calendar_to_epoch_seconds_unit.sv -----
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_in_data   (t_in_data)
// result    out        o_out_valid / i_out_ready    o_out_data  (t_out_data)
//
// Two register stages: an accepted transaction is registered in the date stage
// and then in the result register; a stall at the output holds it in the date
// stage. One transaction is accepted every cycle while results drain.
// The day count and the total-seconds multiply sit in separate stages.
// Reset clears both stage valid flags; no clearing pass is needed.
// A stalled result holds its stage; the date stage keeps accepting until full.
`default_nettype none

module calendar_to_epoch_seconds_unit
    import cte_pkg::*;
#(
    parameter int TICK_RATE = 50
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_data i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_data     o_out_data
);

    logic      mid_valid;
    logic      mid_ready;
    t_mid_data mid_data;

    cte_date_stage #(
        .TICK_RATE (TICK_RATE)
    ) u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_data  (mid_data)
    );

    cte_seconds_stage u_seconds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_data  (mid_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // An accepted transaction always lands in the date stage.
    a_in_to_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> mid_valid)
        else $error("accepted transaction missing from date stage");

    // A transaction leaving the date stage always lands in the result register.
    a_mid_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mid_valid && mid_ready) |=> o_out_valid)
        else $error("date stage transaction missing from result register");

    // Every date in range lies at or after the eve of 2000-01-01.
    a_day_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.day_count >= DAYS_TO_2000 - DAYS_W'(1)))
        else $error("day count below the start of the century");

    // The input side only stalls when both stages hold data.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (mid_valid && o_out_valid && !i_out_ready))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

// ----- src/cte_date_stage.sv -----
// First pipeline stage: day count, minute of day and tick count.
// Computes from the accepted calendar time and registers the partial result.
// Depends on cte_pkg.
`default_nettype none

module cte_date_stage
    import cte_pkg::*;
#(
    parameter int TICK_RATE = 50
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_data  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_mid_data      o_data
);

    localparam int RATE_W = $clog2(TICK_RATE + 1);

    logic      r_valid;
    t_mid_data r_data;
    t_mid_data n_data;

    logic [DAYS_W-1:0]     year_days;
    logic [DAYS_W-1:0]     leap_days;
    logic                  drop_2100;
    logic                  leap_year;
    logic                  leap_add;
    logic [DAYS_W-1:0]     days;
    logic [RATE_W+5:0]     tick_prod;
    logic [RATE_W-1:0]     rate;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign rate    = RATE_W'(TICK_RATE);

    always_comb begin
        year_days = DAYS_TO_2000 + DAYS_PER_YEAR * DAYS_W'(i_data.year_in_century);
        // Leap days in the years from 2000 up to but not including this one;
        // 2100 is the only century year in range that is not a leap year.
        leap_days = DAYS_W'((DAYS_W'(i_data.year_in_century) + DAYS_W'(3)) >> 2);
        drop_2100 = i_data.year_in_century > YEAR_2100;
        leap_year = (i_data.year_in_century[1:0] == 2'b00)
                    && (i_data.year_in_century != YEAR_2100);
        leap_add  = leap_year && (i_data.month_number >= MONTH_MARCH);

        days = year_days + leap_days - DAYS_W'(drop_2100)
             + DAYS_W'(month_offset(i_data.month_number))
             + DAYS_W'(leap_add)
             + DAYS_W'(i_data.day_of_month) - DAYS_W'(1);

        tick_prod = {{RATE_W{1'b0}}, i_data.second_of_minute}
                  * {6'd0, rate};

        n_data.day_count        = days;
        n_data.minute_of_day    = MINS_PER_HOUR * MOD_W'(i_data.hour_of_day)
                                + MOD_W'(i_data.minute_of_hour);
        n_data.tick_count       = TICK_W'(tick_prod);
        n_data.second_of_minute = i_data.second_of_minute;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/cte_seconds_stage.sv -----
// Second pipeline stage: total seconds since the epoch.
// Combines the day count, minute of day and second into the result register.
// Depends on cte_pkg.
`default_nettype none

module cte_seconds_stage
    import cte_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_mid_data i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_data      o_data
);

    logic      r_valid;
    t_out_data r_data;
    t_out_data n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data.day_count     = i_data.day_count;
        n_data.minute_of_day = i_data.minute_of_day;
        n_data.tick_count    = i_data.tick_count;
        // Wraps at 32 bits for the latest dates of the input range.
        n_data.total_seconds = SECS_PER_DAY * TOTAL_W'(i_data.day_count)
                             + SECS_PER_MIN * TOTAL_W'(i_data.minute_of_day)
                             + TOTAL_W'(i_data.second_of_minute);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire
